/* design/dpw_pkg.sv */
// Shared types and constants for the depth pixel to world point pipeline.
// Used by dpw_xform_row and the depth_pixel_to_world_point top level.
package dpw_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_INV_FOCAL_X = 3'd2,
        CFG_INV_FOCAL_Y = 3'd3,
        CFG_XFORM_ROW_X = 3'd4,
        CFG_XFORM_ROW_Y = 3'd5,
        CFG_XFORM_ROW_Z = 3'd6
    } t_cfg_idx;

    localparam logic [15:0] RST_CENTER_X    = 16'd5128;
    localparam logic [15:0] RST_CENTER_Y    = 16'd3848;
    localparam logic [23:0] RST_INV_FOCAL_X = 24'd32129;
    localparam logic [23:0] RST_INV_FOCAL_Y = 24'd32129;
    localparam logic [63:0] RST_XFORM_ROW_X = 64'h4000_0000_0000_0000;
    localparam logic [63:0] RST_XFORM_ROW_Y = 64'h0000_4000_0000_0000;
    localparam logic [63:0] RST_XFORM_ROW_Z = 64'h0000_0000_4000_0000;

    // Camera point widths: x and y in signed Q.4 mm, z unsigned Q.4 mm.
    localparam int CAM_W   = 34;
    localparam int CZ_W    = 20;
    localparam int WORLD_W = 19;

    localparam logic signed [34:0] WORLD_MAX = 35'sd262143;
    localparam logic signed [34:0] WORLD_MIN = -35'sd262144;

    // Stage advance strobes for the transform row stages.
    typedef struct packed {
        logic s5;
        logic s6;
        logic s7;
    } t_row_en;

endpackage

/* design/dpw_xform_row.sv */
// One row of the rigid transform: three products, sum with rounding,
// translation and saturation over three register stages. Depends on dpw_pkg.
module dpw_xform_row import dpw_pkg::*; (
    input  logic                       i_clk,
    input  t_row_en                    i_en,
    input  logic [63:0]                i_row,
    input  logic signed [CAM_W-1:0]    i_cam_x,
    input  logic signed [CAM_W-1:0]    i_cam_y,
    input  logic [CZ_W-1:0]            i_cam_z,
    output logic signed [WORLD_W-1:0]  o_world
);

    logic signed [49:0]        r_px;
    logic signed [49:0]        r_py;
    logic signed [36:0]        r_pz;
    logic signed [51:0]        r_acc;
    logic signed [WORLD_W-1:0] r_world;

    logic signed [49:0]        n_px;
    logic signed [49:0]        n_py;
    logic signed [36:0]        n_pz;
    logic signed [51:0]        n_acc;
    logic signed [33:0]        rnd;
    logic signed [34:0]        sum;
    logic signed [WORLD_W-1:0] n_world;

    always_comb begin
        n_px  = $signed(i_row[63:48]) * i_cam_x;
        n_py  = $signed(i_row[47:32]) * i_cam_y;
        n_pz  = $signed(i_row[31:16]) * $signed({1'b0, i_cam_z});
        // Half an output LSB is added here so the next stage only shifts.
        n_acc = 52'(r_px) + 52'(r_py) + 52'(r_pz) + 52'sd131072;
        rnd   = r_acc[51:18];
        sum   = 35'(rnd) + 35'($signed(i_row[15:0]));
        if (sum > WORLD_MAX) begin
            n_world = WORLD_MAX[WORLD_W-1:0];
        end else if (sum < WORLD_MIN) begin
            n_world = WORLD_MIN[WORLD_W-1:0];
        end else begin
            n_world = sum[WORLD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
        if (i_en.s6) begin
            r_acc <= n_acc;
        end
        if (i_en.s7) begin
            r_world <= n_world;
        end
    end

    assign o_world = r_world;

endmodule

/* design/depth_pixel_to_world_point.sv */
// Top level of the depth pixel to world point pipeline: stream ports,
// configuration registers, back-projection stages. Depends on dpw_pkg, dpw_xform_row.
//
//  Channel  Direction  Transfer when                  Carries
//  s_axis   in         s_axis_tvalid & s_axis_tready  one depth pixel, tlast = frame end
//  m_axis   out        m_axis_tvalid & m_axis_tready  one world point or frame-end marker
//  cfg      in         i_cfg_valid & o_cfg_ready      register index and 64 bit data
//
// One pixel is accepted every cycle unless back-pressure holds s_axis_tready low; its
// result passes through seven register stages, the last of which is the output register:
// offset, depth product, split reciprocal product, rounding sum, transform products, row
// sum and saturation. Each stage holds a valid bit and advances when its successor is
// empty or advancing, so bubbles are squeezed out under a stall and nothing is lost or
// repeated. Pixels that produce no result are dropped at the input stage.
// Reset is synchronous and active low; it clears the valid bits and loads the
// configuration registers with an identity transform and default intrinsics.
module depth_pixel_to_world_point import dpw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // depth_mm[15:0], pixel_col[27:16], pixel_row[39:28], red_in[47:40],
    // green_in[55:48], blue_in[63:56]
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // Point output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // world_x[18:0], world_y[37:19], world_z[56:38], red_out[64:57],
    // green_out[72:65], blue_out[80:73], zeros[87:81]
    output logic [87:0] m_axis_tdata,
    // point_valid[0]
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int NSTG = 7;

    // Configuration registers.
    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [23:0] r_inv_fx;
    logic [23:0] r_inv_fy;
    logic [63:0] r_row_x;
    logic [63:0] r_row_y;
    logic [63:0] r_row_z;

    // Valid bits and per-stage advance strobes.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] en;

    // Side data that rides along every stage.
    logic [NSTG:1]       r_pt;
    logic [NSTG:1]       r_last;
    logic [23:0]         r_rgb [NSTG:1];

    // Arithmetic payload.
    logic signed [17:0]      r_dx;
    logic signed [17:0]      r_dy;
    logic [15:0]             r_depth1;
    logic signed [34:0]      r_px2;
    logic signed [34:0]      r_py2;
    logic [CZ_W-1:0]         r_cz2;
    logic signed [47:0]      r_pxh3;
    logic signed [47:0]      r_pxl3;
    logic signed [47:0]      r_pyh3;
    logic signed [47:0]      r_pyl3;
    logic [CZ_W-1:0]         r_cz3;
    logic signed [CAM_W-1:0] r_cx4;
    logic signed [CAM_W-1:0] r_cy4;
    logic [CZ_W-1:0]         r_cz4;

    logic [15:0]          in_depth;
    logic [11:0]          in_col;
    logic [11:0]          in_row;
    logic                 in_keep;
    logic signed [59:0]   sum_x;
    logic signed [59:0]   sum_y;
    t_row_en              row_en;
    logic signed [WORLD_W-1:0] w_x;
    logic signed [WORLD_W-1:0] w_y;
    logic signed [WORLD_W-1:0] w_z;

    // Configuration port: always ready, unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_inv_fx   <= RST_INV_FOCAL_X;
            r_inv_fy   <= RST_INV_FOCAL_Y;
            r_row_x    <= RST_XFORM_ROW_X;
            r_row_y    <= RST_XFORM_ROW_Y;
            r_row_z    <= RST_XFORM_ROW_Z;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:    r_center_x <= i_cfg_data[15:0];
                CFG_CENTER_Y:    r_center_y <= i_cfg_data[15:0];
                CFG_INV_FOCAL_X: r_inv_fx   <= i_cfg_data[23:0];
                CFG_INV_FOCAL_Y: r_inv_fy   <= i_cfg_data[23:0];
                CFG_XFORM_ROW_X: r_row_x    <= i_cfg_data;
                CFG_XFORM_ROW_Y: r_row_y    <= i_cfg_data;
                CFG_XFORM_ROW_Z: r_row_z    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb begin
        en[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];

    assign in_depth = s_axis_tdata[15:0];
    assign in_col   = s_axis_tdata[27:16];
    assign in_row   = s_axis_tdata[39:28];
    // A pixel without depth only produces a result when it closes the frame.
    assign in_keep  = (in_depth != 16'd0) || s_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= s_axis_tvalid && in_keep;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Side data. A marker carries zero color so the output needs no extra mux there.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_pt[1]   <= in_depth != 16'd0;
            r_last[1] <= s_axis_tlast;
            r_rgb[1]  <= (in_depth != 16'd0) ? s_axis_tdata[63:40] : 24'd0;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (en[k]) begin
                r_pt[k]   <= r_pt[k-1];
                r_last[k] <= r_last[k-1];
                r_rgb[k]  <= r_rgb[k-1];
            end
        end
    end

    // Stage 1: pixel offset from the principal point in Q.4 pixels.
    // Stage 2: offset times depth.
    // Stage 3: times the reciprocal focal length, split in two 12 bit halves.
    // Stage 4: recombine the halves and round to Q.4 mm.
    always_comb begin
        sum_x = (60'(r_pxh3) <<< 12) + 60'(r_pxl3) + 60'sd8388608;
        sum_y = (60'(r_pyh3) <<< 12) + 60'(r_pyl3) + 60'sd8388608;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_dx     <= $signed({2'b00, in_col, 4'b0000}) - $signed({2'b00, r_center_x});
            r_dy     <= $signed({2'b00, in_row, 4'b0000}) - $signed({2'b00, r_center_y});
            r_depth1 <= in_depth;
        end
        if (en[2]) begin
            r_px2 <= r_dx * $signed({1'b0, r_depth1});
            r_py2 <= r_dy * $signed({1'b0, r_depth1});
            r_cz2 <= {r_depth1, 4'b0000};
        end
        if (en[3]) begin
            r_pxh3 <= r_px2 * $signed({1'b0, r_inv_fx[23:12]});
            r_pxl3 <= r_px2 * $signed({1'b0, r_inv_fx[11:0]});
            r_pyh3 <= r_py2 * $signed({1'b0, r_inv_fy[23:12]});
            r_pyl3 <= r_py2 * $signed({1'b0, r_inv_fy[11:0]});
            r_cz3  <= r_cz2;
        end
        if (en[4]) begin
            r_cx4 <= sum_x[57:24];
            r_cy4 <= sum_y[57:24];
            r_cz4 <= r_cz3;
        end
    end

    // Stages 5 to 7: one transform row per instance.
    always_comb begin
        row_en.s5 = en[5];
        row_en.s6 = en[6];
        row_en.s7 = en[7];
    end

    dpw_xform_row u_row_x (
        .i_clk   (i_clk),
        .i_en    (row_en),
        .i_row   (r_row_x),
        .i_cam_x (r_cx4),
        .i_cam_y (r_cy4),
        .i_cam_z (r_cz4),
        .o_world (w_x)
    );

    dpw_xform_row u_row_y (
        .i_clk   (i_clk),
        .i_en    (row_en),
        .i_row   (r_row_y),
        .i_cam_x (r_cx4),
        .i_cam_y (r_cy4),
        .i_cam_z (r_cz4),
        .o_world (w_y)
    );

    dpw_xform_row u_row_z (
        .i_clk   (i_clk),
        .i_en    (row_en),
        .i_row   (r_row_z),
        .i_cam_x (r_cx4),
        .i_cam_y (r_cy4),
        .i_cam_z (r_cz4),
        .o_world (w_z)
    );

    // Output register is stage 7. A frame-end marker shows zero coordinates.
    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tuser  = r_pt[NSTG];
    assign m_axis_tlast  = r_last[NSTG];
    assign m_axis_tdata  = {7'd0, r_rgb[NSTG],
                            r_pt[NSTG] ? w_z : '0,
                            r_pt[NSTG] ? w_y : '0,
                            r_pt[NSTG] ? w_x : '0};

`ifndef SYNTH
    // A frame-end marker carries no coordinates or color and always closes a frame.
    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 88'd0 && m_axis_tlast))
        else $error("frame-end marker carries data or lacks tlast");

    // With the output register empty the ready chain must open the input.
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    // No result may appear right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
